### rtl/indexed_list_engine_top_defines.svh
// Assertion macros shared by the indexed list engine RTL.
`ifndef INDEXED_LIST_ENGINE_TOP_DEFINES_SVH
`define INDEXED_LIST_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define ILE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("indexed list engine: assertion failed");
// Checks a property at every rising clock edge, reset included.
`define ILE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("indexed list engine: assertion failed");
`else
`define ILE_ASSERT(label, prop)
`define ILE_ASSERT_ALWAYS(label, prop)
`endif

`endif

### rtl/ile_pkg.sv
// Types and constants of the indexed list engine.
package ile_pkg;

  localparam int unsigned CapacityDefault = 256;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW = 8;
  localparam int unsigned EntryCountW = 9;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_APPEND = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain in the same cycle.
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef struct packed {
    op_e                      op;
    logic [PosW-1:0]          position;
    logic signed [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    status_e                  status;
    logic [EntryCountW-1:0]   entry_count;
  } rsp_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [PosW-1:0]   pos;
    logic [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

### rtl/ile_cell.sv
// One storage cell of the list chain, holding the entry at a fixed position.
module ile_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 9
) (
  input  logic                        clk_i,
  input  ile_pkg::cell_ctrl_t         ctrl_i,
  input  logic [CntW-1:0]             count_i,
  input  logic [ile_pkg::ValueW-1:0]  left_i,
  input  logic [ile_pkg::ValueW-1:0]  right_i,
  output logic [ile_pkg::ValueW-1:0]  value_o
);
  import ile_pkg::*;

  // Common compare width for the 8-bit position, the count and the index.
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CmpW-1:0] Idx = CmpW'(Index);

  logic [CmpW-1:0]   pos_w;
  logic [CmpW-1:0]   cnt_w;
  logic [ValueW-1:0] value_d;
  logic [ValueW-1:0] value_q;

  assign pos_w = CmpW'(ctrl_i.pos);
  assign cnt_w = CmpW'(count_i);

  // An insert pulls the neighbor toward the head, a delete the one toward the tail.
  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (Idx == pos_w) begin
          value_d = ctrl_i.value;
        end else if (Idx > pos_w) begin
          value_d = left_i;
        end
      end
      CMD_APPEND: begin
        if (Idx == cnt_w) begin
          value_d = ctrl_i.value;
        end
      end
      CMD_DELETE: begin
        if (Idx >= pos_w) begin
          value_d = right_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

### rtl/indexed_list_engine_top.sv
// Top level of the indexed list engine: request decode, count, cell chain and result register.
`include "indexed_list_engine_top_defines.svh"

// The engine keeps an ordered list of up to Capacity signed 32-bit entries
// and serves one request per clock cycle: read, insert at a position, append
// at the tail, or delete at a position. Every entry sits in a cell of its own,
// and an insert or delete moves all the affected cells toward the tail or the
// head in the same cycle, so each request completes in the cycle it is
// accepted and its result stands in the output register from the next cycle.
// A new request is taken while the result of the previous one is still
// waiting as long as the consumer takes that result in the same cycle, which
// gives a sustained rate of one request per cycle. Only the first 256
// positions can be addressed; entries beyond them fill by append or shift.
// A position outside the list answers an out-of-range status, an insert or
// append into a full list answers a full status, and neither changes the list.
// Reset clears only the count and the response valid flag; the entry cells
// need no clearing pass, because no entry at or beyond the count is ever read.
module indexed_list_engine_top #(
  parameter int unsigned Capacity = ile_pkg::CapacityDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  ile_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output ile_pkg::rsp_t rsp_o
);
  import ile_pkg::*;

  // The count must be able to hold Capacity itself.
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  // Only the cells below position 256 can be read.
  localparam int unsigned ReadN = (Capacity > (1 << PosW)) ? (1 << PosW) : Capacity;
  localparam int unsigned RdW = $clog2(ReadN);
  localparam logic [CntW-1:0] CapCount = CntW'(Capacity);

  logic [CntW-1:0]   count_d;
  logic [CntW-1:0]   count_q;
  logic              rsp_valid_d;
  logic              rsp_valid_q;
  rsp_t              rsp_d;
  rsp_t              rsp_q;
  logic              req_fire;
  logic              full;
  logic [CmpW-1:0]   pos_w;
  logic [CmpW-1:0]   cnt_w;
  cell_ctrl_t        ctrl;
  status_e           status;
  logic [ValueW-1:0] rd_value;

  logic [ValueW-1:0] cell_value [Capacity];

  // The result register frees itself whenever the consumer takes its content.
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign req_fire    = req_valid_i && req_ready_o;

  assign full  = (count_q == CapCount);
  assign pos_w = CmpW'(req_i.position);
  assign cnt_w = CmpW'(count_q);

  // Decode the request into a status, a cell command and the next count.
  // The cells see a command only for an accepted request that changes the list.
  always_comb begin
    status    = ST_DONE;
    ctrl.cmd  = CMD_NONE;
    ctrl.pos  = req_i.position;
    ctrl.value = req_i.value;
    count_d   = count_q;
    rd_value  = '0;
    unique case (req_i.op)
      OP_READ: begin
        if (pos_w < cnt_w) begin
          rd_value = cell_value[RdW'(req_i.position)];
        end else begin
          status = ST_RANGE;
        end
      end
      OP_INSERT: begin
        if (pos_w > cnt_w) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else if (req_fire) begin
          ctrl.cmd = CMD_INSERT;
          count_d  = count_q + CntW'(1);
        end
      end
      OP_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else if (req_fire) begin
          ctrl.cmd = CMD_APPEND;
          count_d  = count_q + CntW'(1);
        end
      end
      OP_DELETE: begin
        if (pos_w < cnt_w) begin
          if (req_fire) begin
            ctrl.cmd = CMD_DELETE;
            count_d  = count_q - CntW'(1);
          end
        end else begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  // Result of the request taken in this cycle; the count is reported in 9 bits.
  always_comb begin
    rsp_d             = rsp_q;
    rsp_valid_d       = rsp_valid_q && !rsp_ready_i;
    if (req_fire) begin
      rsp_valid_d       = 1'b1;
      rsp_d.read_value  = $signed(rd_value);
      rsp_d.status      = status;
      rsp_d.entry_count = EntryCountW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // The chain of cells: each cell sees its neighbors toward the head and the tail.
  for (genvar gi = 0; gi < Capacity; gi++) begin : g_cell
    logic [ValueW-1:0] left_w;
    logic [ValueW-1:0] right_w;

    if (gi == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_value[gi-1];
    end

    if (gi == Capacity - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_value[gi+1];
    end

    ile_cell #(
      .Index (gi),
      .CntW  (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (cell_value[gi])
    );
  end

  `ILE_ASSERT_ALWAYS(a_count_in_range, count_q <= CapCount)
  `ILE_ASSERT(a_full_keeps_count, (req_fire && status == ST_FULL) |=> (count_q == $past(count_q)))
  `ILE_ASSERT(a_range_keeps_count, (req_fire && status == ST_RANGE) |=> (count_q == $past(count_q)))
  `ILE_ASSERT(a_error_reads_zero, (rsp_valid_o && rsp_o.status != ST_DONE) |-> (rsp_o.read_value == 0))
  `ILE_ASSERT(a_count_reported, rsp_valid_o |-> (rsp_o.entry_count == EntryCountW'(count_q)))

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the indexed list engine: random and directed list requests.
`timescale 1ns / 100ps

// The bench drives list requests into the engine through its valid/ready
// request port. A shadow copy of the list, kept inside a small class, works
// out the response that each accepted request must produce and queues it.
// Responses are taken off the output port under random back-pressure and
// compared field by field with the oldest queued expectation.
module testbench;
  import ile_pkg::*;

  localparam int unsigned ListCapacity = CapacityDefault;
  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned DrainCycles  = 10;
  localparam int unsigned PhaseItems   = 525;

  // Shadow of the list contents and the queue of responses still owed by the engine.
  class ListShadow;
    logic signed [ValueW-1:0] shadow_entries [ListCapacity];
    int unsigned              shadow_count;
    rsp_t                     awaited_rsps [$];
    int unsigned              failures;

    function new();
      shadow_count = 0;
      failures     = 0;
    endfunction

    // Applies one accepted request to the shadow list and queues its response.
    function void take_request(req_t req);
      rsp_t        want;
      int unsigned pos;
      int          i;
      want        = '0;
      want.status = ST_DONE;
      pos         = 32'(req.position);
      case (req.op)
        OP_READ: begin
          if (pos < shadow_count) want.read_value = shadow_entries[pos];
          else want.status = ST_RANGE;
        end
        OP_INSERT: begin
          if (pos > shadow_count) begin
            want.status = ST_RANGE;
          end else if (shadow_count >= ListCapacity) begin
            want.status = ST_FULL;
          end else begin
            for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[pos] = req.value;
            shadow_count++;
          end
        end
        OP_APPEND: begin
          if (shadow_count >= ListCapacity) begin
            want.status = ST_FULL;
          end else begin
            shadow_entries[shadow_count] = req.value;
            shadow_count++;
          end
        end
        default: begin
          if (pos < shadow_count) begin
            for (i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
            shadow_count--;
          end else begin
            want.status = ST_RANGE;
          end
        end
      endcase
      want.entry_count = shadow_count[EntryCountW-1:0];
      awaited_rsps.push_back(want);
    endfunction

    // Compares one accepted response with the oldest expectation.
    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited_rsps.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("unexpected response: read_value %0d status %0d entry_count %0d",
                   got.read_value, got.status, got.entry_count);
        return;
      end
      want = awaited_rsps.pop_front();
      if (got.read_value !== want.read_value || got.status !== want.status ||
          got.entry_count !== want.entry_count) begin
        failures++;
        if (failures <= ReportLimit)
          $display("response mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                   want.read_value, want.status, want.entry_count,
                   got.read_value, got.status, got.entry_count);
      end
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  req_valid_i;
  logic  req_ready_o;
  req_t  req_i;
  logic  rsp_valid_o;
  logic  rsp_ready_i;
  rsp_t  rsp_o;

  // Percentages of cycles in which the request side holds back and the
  // response side stalls; the main sequence changes them phase by phase.
  int unsigned req_idle_pct  = 36;
  int unsigned rsp_stall_pct = 61;

  // The random sequence alternates between growing the list toward full and
  // shrinking it toward empty, so both the full and the empty corners are hit.
  bit growing = 1'b1;

  ListShadow list_shadow = new();

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  indexed_list_engine_top #(
    .Capacity(ListCapacity)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  // Response side: a response is taken at every edge where valid and ready
  // are both high, and ready is redrawn for the next cycle at the same edge.
  always @(posedge clk_i) begin
    if (rsp_valid_o && rsp_ready_i) list_shadow.check_response(rsp_o);
    rsp_ready_i <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // Presents one request and returns at the edge where it is accepted. Valid
  // is lowered only when an idle gap is drawn, so back-to-back requests keep
  // it high and give each signal a single update per edge.
  task automatic send_request(input req_t req);
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= req;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    list_shadow.take_request(req);
  endtask

  task automatic send_op(input op_e op, input int unsigned pos,
                         input logic signed [ValueW-1:0] val);
    req_t req;
    req.op       = op;
    req.position = pos[PosW-1:0];
    req.value    = val;
    send_request(req);
  endtask

  // Draws one random request. Most requests are well formed for the current
  // list length; the rest use an arbitrary position, which is mostly out of
  // range once the list is short.
  task automatic send_random(input int unsigned n);
    req_t        req;
    int unsigned roll;
    int unsigned used;
    int unsigned k;
    for (k = 0; k < n; k++) begin
      used = list_shadow.shadow_count;
      if (used == 0) growing = 1'b1;
      else if (used >= ListCapacity && $urandom_range(7) == 0) growing = 1'b0;

      roll = $urandom_range(99);
      if (growing) begin
        if (roll < 35) req.op = OP_APPEND;
        else if (roll < 75) req.op = OP_INSERT;
        else if (roll < 90) req.op = OP_READ;
        else req.op = OP_DELETE;
      end else begin
        if (roll < 75) req.op = OP_DELETE;
        else if (roll < 90) req.op = OP_READ;
        else if (roll < 95) req.op = OP_INSERT;
        else req.op = OP_APPEND;
      end

      roll = $urandom_range(99);
      if (roll < 85 && req.op == OP_INSERT) begin
        req.position = (used > 255) ? PosW'($urandom_range(255)) : PosW'($urandom_range(used));
      end else if (roll < 85 && used > 0) begin
        req.position = (used > 256) ? PosW'($urandom_range(255)) :
                                      PosW'($urandom_range(used - 1));
      end else if (roll < 90) begin
        // Position right at the list length: the tail for an insert and
        // just out of range for a read or a delete.
        req.position = (used > 255) ? 8'd255 : used[PosW-1:0];
      end else begin
        req.position = PosW'($urandom_range(255));
      end

      case ($urandom_range(19))
        0:       req.value = {1'b1, {(ValueW-1){1'b0}}};
        1:       req.value = {1'b0, {(ValueW-1){1'b1}}};
        2:       req.value = '0;
        3:       req.value = '1;
        default: req.value = $urandom;
      endcase
      send_request(req);
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    req_valid_i <= 1'b0;
    req_i       <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. On the empty list every read, delete and insert past
    // the head is out of range.
    send_op(OP_READ,     0, 32'sd0);
    send_op(OP_DELETE,   0, 32'sd0);
    send_op(OP_INSERT,   1, 32'sd7);
    send_op(OP_INSERT, 255, 32'sd7);
    // Head inserts, an append, a tail insert and a middle insert with the value extremes.
    send_op(OP_INSERT,   0, {1'b1, {(ValueW-1){1'b0}}});
    send_op(OP_APPEND,   0, {1'b0, {(ValueW-1){1'b1}}});
    send_op(OP_INSERT,   0, -32'sd1);
    send_op(OP_INSERT,   3, 32'sd0);
    send_op(OP_INSERT,   2, 32'h5A5A_A5A5);
    for (int unsigned p = 0; p < 5; p++) send_op(OP_READ, p, 32'sd0);
    send_op(OP_READ,     5, 32'sd0);
    send_op(OP_READ,   255, 32'h1234_5678);
    // Deletes at the tail, the head and in the middle shift the rest.
    send_op(OP_DELETE,   4, 32'sd0);
    send_op(OP_DELETE,   0, 32'sd0);
    send_op(OP_DELETE,   1, 32'sd0);
    send_op(OP_READ,     0, 32'sd0);
    send_op(OP_READ,     1, 32'sd0);
    send_op(OP_DELETE, 255, 32'sd0);
    // The position of an append is ignored.
    send_op(OP_APPEND, 255, 32'h0F0F_F0F0);
    send_op(OP_READ,     2, 32'sd0);

    // Random part in three phases: a slow consumer, then a slow producer,
    // then full speed on both sides.
    send_random(PhaseItems - 25);
    req_idle_pct  = 61;
    rsp_stall_pct = 36;
    send_random(PhaseItems);
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    send_random(PhaseItems);
    req_valid_i <= 1'b0;

    while (list_shadow.awaited_rsps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (list_shadow.failures == 0 && list_shadow.awaited_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs and reports it as failed.
  initial begin
    #(2_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/indexed_list_engine_top.sv
tb/sv/testbench.sv
